@@ design/rks_pkg.sv @@
package rks_pkg;

    // Field widths of one record.
    localparam int unsigned RollW        = 16;
    localparam int unsigned NameHighW    = 64;
    localparam int unsigned NameMiddleW  = 64;
    localparam int unsigned NameLowW     = 32;
    localparam int unsigned NameW        = NameHighW + NameMiddleW + NameLowW;
    localparam int unsigned NameBytesMax = NameW / 8;
    localparam int unsigned MarksW       = 14;
    localparam int unsigned KeyW         = 2;

    // Sort key codes held in the configuration register.
    typedef enum logic [KeyW-1:0] {
        KeyRoll  = 2'd0,
        KeyName  = 2'd1,
        KeyMarks = 2'd2,
        KeyNone  = 2'd3
    } t_sort_key;

    // One stored record; byte 0 of the name sits in the top byte.
    typedef struct packed {
        logic [RollW-1:0]  roll;
        logic [NameW-1:0]  name;
        logic [MarksW-1:0] marks;
    } t_rec;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_GET_I,
        ST_CMP,
        ST_PUT_I,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    // Mask that keeps the first nbytes name bytes and clears the rest.
    function automatic logic [NameW-1:0] name_keep_mask(int unsigned nbytes);
        logic [NameW-1:0] m;
        m = '0;
        for (int unsigned b = 0; b < NameBytesMax; b++) begin
            if (b < nbytes) begin
                m[NameW-1-8*b -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

@@ design/rks_if.sv @@
// Record input channel.
interface rks_in_if;
    logic                           valid;
    logic                           ready;
    logic [rks_pkg::RollW-1:0]      roll_number;
    logic [rks_pkg::NameHighW-1:0]  name_bytes_0_7;
    logic [rks_pkg::NameMiddleW-1:0] name_bytes_8_15;
    logic [rks_pkg::NameLowW-1:0]   name_bytes_16_19;
    logic [rks_pkg::MarksW-1:0]     marks_centi;
    logic                           last_record;

    modport source (
        output valid, roll_number, name_bytes_0_7, name_bytes_8_15,
               name_bytes_16_19, marks_centi, last_record,
        input  ready
    );
    modport sink (
        input  valid, roll_number, name_bytes_0_7, name_bytes_8_15,
               name_bytes_16_19, marks_centi, last_record,
        output ready
    );
endinterface

// Sorted record output channel.
interface rks_out_if;
    logic                           valid;
    logic                           ready;
    logic [rks_pkg::RollW-1:0]      out_roll_number;
    logic [rks_pkg::NameHighW-1:0]  out_name_bytes_0_7;
    logic [rks_pkg::NameMiddleW-1:0] out_name_bytes_8_15;
    logic [rks_pkg::NameLowW-1:0]   out_name_bytes_16_19;
    logic [rks_pkg::MarksW-1:0]     out_marks_centi;
    logic                           out_last;
    logic                           overflowed;

    modport source (
        output valid, out_roll_number, out_name_bytes_0_7, out_name_bytes_8_15,
               out_name_bytes_16_19, out_marks_centi, out_last, overflowed,
        input  ready
    );
    modport sink (
        input  valid, out_roll_number, out_name_bytes_0_7, out_name_bytes_8_15,
               out_name_bytes_16_19, out_marks_centi, out_last, overflowed,
        output ready
    );
endinterface

@@ design/rks_store.sv @@
// Record table: one write port and one read port with registered read data.
module rks_store #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  rks_pkg::t_rec            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output rks_pkg::t_rec            o_rdata
);

    rks_pkg::t_rec r_mem [DEPTH];
    rks_pkg::t_rec r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/rks_cmp.sv @@
// Compare unit: says whether record a must come after record b.
module rks_cmp (
    input  rks_pkg::t_sort_key i_key,
    input  rks_pkg::t_rec      i_a,
    input  rks_pkg::t_rec      i_b,
    output logic               o_swap
);

    localparam int unsigned Nb = rks_pkg::NameBytesMax;

    logic [Nb-1:0]                 zero_a;
    logic [Nb-1:0]                 zero_b;
    logic [rks_pkg::NameW-1:0]     trim_a;
    logic [rks_pkg::NameW-1:0]     trim_b;
    logic                          name_after;

    // Clear every byte after the first zero byte, so that a plain magnitude
    // compare of the trimmed names orders them as a C string compare does.
    always_comb begin
        for (int unsigned p = 0; p < Nb; p++) begin
            zero_a[p] = (i_a.name[rks_pkg::NameW-1-8*p -: 8] == 8'h00);
            zero_b[p] = (i_b.name[rks_pkg::NameW-1-8*p -: 8] == 8'h00);
        end
        for (int unsigned p = 0; p < Nb; p++) begin
            trim_a[rks_pkg::NameW-1-8*p -: 8] =
                (|(zero_a & Nb'((64'd1 << p) - 64'd1))) ? 8'h00
                                                         : i_a.name[rks_pkg::NameW-1-8*p -: 8];
            trim_b[rks_pkg::NameW-1-8*p -: 8] =
                (|(zero_b & Nb'((64'd1 << p) - 64'd1))) ? 8'h00
                                                         : i_b.name[rks_pkg::NameW-1-8*p -: 8];
        end
        name_after = (trim_a > trim_b);
    end

    // Key select; equal keys never swap.
    always_comb begin
        unique case (i_key)
            rks_pkg::KeyRoll:  o_swap = (i_a.roll > i_b.roll);
            rks_pkg::KeyName:  o_swap = name_after;
            rks_pkg::KeyMarks: o_swap = (i_a.marks < i_b.marks);
            rks_pkg::KeyNone:  o_swap = 1'b0;
            default:           o_swap = 1'b0;
        endcase
    end

endmodule

@@ design/record_table_key_sorter_unit.sv @@
// Channel   Direction  Transfer moves
// i_rec     in         one record (roll, 20 name bytes, marks, last flag)
// o_res     out        one sorted record with last and overflow flags
// i_cfg_*   in         sort key write, no handshake
//
// Loading takes one record per cycle. The record flagged last starts an exchange
// sort of n records, one compare per cycle in the compare state, through the single read
// port of the table; with key 3 or one record it is skipped.
// Emission then passes through a read state and gives up to one record per cycle.
// Reset is synchronous, active low, and empties the table; no clearing pass runs.
// The input is not ready from the last record until the final result is taken.
module record_table_key_sorter_unit #(
    parameter int unsigned TABLE_DEPTH = 32,
    parameter int unsigned NAME_BYTES  = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rks_pkg::KeyW-1:0]     i_cfg_wdata,
    rks_in_if.sink                       i_rec,
    rks_out_if.source                    o_res
);

    localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
    localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
    localparam logic [rks_pkg::NameW-1:0] NameKeep =
        rks_pkg::name_keep_mask(NAME_BYTES);

    rks_pkg::t_state    r_state, n_state;
    rks_pkg::t_sort_key r_key;
    logic [CntW-1:0]    r_cnt, n_cnt;
    logic               r_drop, n_drop;
    logic [IdxW-1:0]    r_i, n_i;
    logic [IdxW-1:0]    r_j, n_j;
    rks_pkg::t_rec      r_cur, n_cur;

    logic [CntW-1:0]    cnt_acc;
    logic               mem_we;
    logic [IdxW-1:0]    mem_waddr;
    rks_pkg::t_rec      mem_wdata;
    logic               mem_re;
    logic [IdxW-1:0]    mem_raddr;
    rks_pkg::t_rec      mem_rdata;
    rks_pkg::t_rec      in_rec;
    logic               swap;
    logic               emit_last;
    logic               in_ready;
    logic               out_valid;

    rks_store #(
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Record i is held in r_cur; the table output holds record j.
    rks_cmp u_cmp (
        .i_key  (r_key),
        .i_a    (r_cur),
        .i_b    (mem_rdata),
        .o_swap (swap)
    );

    // Incoming record with name bytes beyond the configured length cleared.
    always_comb begin
        in_rec.roll  = i_rec.roll_number;
        in_rec.name  = {i_rec.name_bytes_0_7, i_rec.name_bytes_8_15,
                        i_rec.name_bytes_16_19} & NameKeep;
        in_rec.marks = i_rec.marks_centi;
    end

    assign emit_last = ((CntW'(r_i) + 1'b1) == r_cnt);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= rks_pkg::KeyRoll;
        end else if (i_cfg_we) begin
            r_key <= rks_pkg::t_sort_key'(i_cfg_wdata);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rks_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // Held record for the outer position.
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    // Sequencer: load, exchange sort over the table, then emission.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_i       = r_i;
        n_j       = r_j;
        n_cur     = r_cur;
        cnt_acc   = r_cnt;
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = r_cur;
        mem_re    = 1'b0;
        mem_raddr = r_i;
        in_ready  = 1'b0;
        out_valid = 1'b0;

        unique case (r_state)
            rks_pkg::ST_LOAD: begin
                in_ready  = 1'b1;
                // Keep entry 0 on the read port for the first outer position.
                mem_re    = 1'b1;
                mem_raddr = '0;
                if (i_rec.valid) begin
                    if (r_cnt < CntW'(TABLE_DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_cnt[IdxW-1:0];
                        mem_wdata = in_rec;
                        cnt_acc   = r_cnt + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_cnt = cnt_acc;
                    if (i_rec.last_record) begin
                        n_i = '0;
                        if (r_key == rks_pkg::KeyNone || cnt_acc < CntW'(2)) begin
                            n_state = rks_pkg::ST_EMIT_RD;
                        end else begin
                            n_state = rks_pkg::ST_GET_I;
                        end
                    end
                end
            end
            rks_pkg::ST_GET_I: begin
                n_cur     = mem_rdata;
                n_j       = r_i + 1'b1;
                mem_re    = 1'b1;
                mem_raddr = r_i + 1'b1;
                n_state   = rks_pkg::ST_CMP;
            end
            rks_pkg::ST_CMP: begin
                if (swap) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_j;
                    mem_wdata = r_cur;
                    n_cur     = mem_rdata;
                end
                if ((CntW'(r_j) + 1'b1) == r_cnt) begin
                    n_state = rks_pkg::ST_PUT_I;
                end else begin
                    n_j       = r_j + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = r_j + 1'b1;
                end
            end
            rks_pkg::ST_PUT_I: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_cur;
                if ((CntW'(r_i) + CntW'(2)) == r_cnt) begin
                    n_i     = '0;
                    n_state = rks_pkg::ST_EMIT_RD;
                end else begin
                    n_i       = r_i + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = r_i + 1'b1;
                    n_state   = rks_pkg::ST_GET_I;
                end
            end
            rks_pkg::ST_EMIT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_i;
                n_state   = rks_pkg::ST_EMIT;
            end
            rks_pkg::ST_EMIT: begin
                out_valid = 1'b1;
                if (o_res.ready) begin
                    if (emit_last) begin
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_state = rks_pkg::ST_LOAD;
                    end else begin
                        // Fetch the next record in the same cycle as the transfer.
                        n_i       = r_i + 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = r_i + 1'b1;
                    end
                end
            end
            default: begin
                n_state = rks_pkg::ST_LOAD;
            end
        endcase
    end

    // Channel outputs; the payload comes straight from the table read register.
    assign i_rec.ready                = in_ready;
    assign o_res.valid                = out_valid;
    assign o_res.out_roll_number      = mem_rdata.roll;
    assign o_res.out_name_bytes_0_7   = mem_rdata.name[rks_pkg::NameW-1 -: rks_pkg::NameHighW];
    assign o_res.out_name_bytes_8_15  =
        mem_rdata.name[rks_pkg::NameLowW+rks_pkg::NameMiddleW-1 -: rks_pkg::NameMiddleW];
    assign o_res.out_name_bytes_16_19 = mem_rdata.name[rks_pkg::NameLowW-1:0];
    assign o_res.out_marks_centi      = mem_rdata.marks;
    assign o_res.out_last             = emit_last;
    assign o_res.overflowed           = r_drop;

endmodule
